// ===== rtl/sset_pkg.sv =====
package sset_pkg;

   localparam int MAX_SIDE = 64;
   localparam int WINDOW = 3;

   localparam int HALF = WINDOW / 2;
   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int LIM_BITS = SIDE_BITS + 1;
   localparam int CFG_SIDE_BITS = 7;
   localparam int CMP_BITS = (LIM_BITS > CFG_SIDE_BITS) ? LIM_BITS : CFG_SIDE_BITS;
   localparam int COORD_BITS = SIDE_BITS + 2;
   localparam int OFS_BITS = $clog2(WINDOW);
   localparam int LAYER_BITS = 2;
   localparam int ADDR_BITS = LAYER_BITS + 2 * SIDE_BITS;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;
   localparam int PIX_BITS = 16;
   localparam int THR_BITS = 15;
   localparam int COL_BITS = 6;
   localparam int ROW_BITS = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   localparam logic [LAYER_BITS-1:0] LAYER_LOWER = 2'd0;
   localparam logic [LAYER_BITS-1:0] LAYER_CENTRE = 2'd1;
   localparam logic [LAYER_BITS-1:0] LAYER_UPPER = 2'd2;
   localparam logic [LAYER_BITS-1:0] LAYER_NONE = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT = 2'd2;

   typedef logic [SIDE_BITS-1:0] coord_type;
   typedef logic [LIM_BITS-1:0] lim_type;
   typedef logic [OFS_BITS-1:0] ofs_type;

   // Size register to active side length: zero acts as one, large values saturate.
   function automatic lim_type side_limit(input logic [CFG_SIDE_BITS-1:0] v);
      logic [CMP_BITS-1:0] ext;
      ext = CMP_BITS'(v);
      if (ext == '0) begin
         return lim_type'(1);
      end else if (ext > CMP_BITS'(MAX_SIDE)) begin
         return lim_type'(MAX_SIDE);
      end else begin
         return lim_type'(ext);
      end
   endfunction

   // Clamp a non-negative position into the active area.
   function automatic coord_type clamp_pos(input logic [CMP_BITS-1:0] v, input lim_type lim);
      logic [CMP_BITS-1:0] lim_ext;
      lim_ext = CMP_BITS'(lim);
      if (v >= lim_ext) begin
         return coord_type'(lim_ext - CMP_BITS'(1));
      end else begin
         return coord_type'(v);
      end
   endfunction

   // Neighbour coordinate: centre plus window offset, clamped to the edge.
   function automatic coord_type clamp_ofs(input coord_type c, input ofs_type d,
                                           input lim_type lim);
      logic signed [COORD_BITS-1:0] v;
      logic signed [COORD_BITS-1:0] lim_ext;
      v = signed'(COORD_BITS'(c)) + signed'(COORD_BITS'(d)) - signed'(COORD_BITS'(HALF));
      lim_ext = signed'(COORD_BITS'(lim));
      if (v < 0) begin
         return '0;
      end else if (v >= lim_ext) begin
         return coord_type'(lim_ext - signed'(COORD_BITS'(1)));
      end else begin
         return coord_type'(v);
      end
   endfunction

endpackage

// ===== rtl/scale_space_extremum_test_top.sv =====
// Scale-space extremum test over three difference-of-Gaussian layers held in one
// single-port memory (lower, centre and upper layer side by side, one read or write
// per cycle). A load transaction writes one Q8.8 pixel (none for LAYER_NONE) and
// answers with an all-zero result in the next cycle; a following transaction can be
// taken in the next cycle unless that result is stalled. A test transaction reads
// the centre pixel in the accept cycle, then the 26 neighbours in the lower, upper
// and centre layers, one memory read per cycle, then a state for the last read data
// and a state that registers the result, held while the output is stalled. The
// single memory port serialises the reads. Neighbour coordinates are clamped to
// the area set by the size registers. A pixel must be loaded before a test reads it.
module scale_space_extremum_test_top
   import sset_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [1:0]                  req_layer,
   input  logic [5:0]                  req_col,
   input  logic [5:0]                  req_row,
   input  logic signed [15:0]          req_pixel_value,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_keypoint,
   output logic signed [15:0]          rsp_centre_value,
   output logic signed [15:0]          rsp_neigh_min,
   output logic signed [15:0]          rsp_neigh_max,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic signed [PIX_BITS-1:0] PIX_MAX = {1'b0, {(PIX_BITS-1){1'b1}}};
   localparam logic signed [PIX_BITS-1:0] PIX_MIN = {1'b1, {(PIX_BITS-1){1'b0}}};

   logic [THR_BITS-1:0]      threshold_ff;
   logic [CFG_SIDE_BITS-1:0] width_ff;
   logic [CFG_SIDE_BITS-1:0] height_ff;

   logic [1:0]               state_ff, state_in;
   logic [LAYER_BITS-1:0]    layer_ff, layer_in;
   ofs_type                  du_ff, du_in;
   ofs_type                  dv_ff, dv_in;
   coord_type                cx_ff, cx_in;
   coord_type                cy_ff, cy_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     rd_centre_ff, rd_centre_in;
   logic signed [PIX_BITS-1:0] centre_ff, centre_in;
   logic signed [PIX_BITS-1:0] mn_ff, mn_in;
   logic signed [PIX_BITS-1:0] mx_ff, mx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic signed [PIX_BITS-1:0] rsp_centre_ff, rsp_centre_in;
   logic signed [PIX_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic signed [PIX_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic                     out_free;
   logic                     accept;
   lim_type                  w_lim;
   lim_type                  h_lim;
   coord_type                req_cx;
   coord_type                req_cy;
   coord_type                scan_r;
   coord_type                scan_k;
   logic                     load_in_range;
   logic                     mem_en;
   logic                     mem_we;
   logic [ADDR_BITS-1:0]     mem_addr;
   logic [PIX_BITS-1:0]      mem_rdata;
   logic signed [PIX_BITS-1:0] rd_pix;
   logic                     scan_done;
   logic [PIX_BITS:0]        mag;
   logic                     hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         width_ff <= CFG_SIDE_BITS'(64);
         height_ff <= CFG_SIDE_BITS'(64);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_data[THR_BITS-1:0];
            REG_WIDTH:     width_ff <= csr_data[CFG_SIDE_BITS-1:0];
            REG_HEIGHT:    height_ff <= csr_data[CFG_SIDE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign w_lim = side_limit(width_ff);
   assign h_lim = side_limit(height_ff);
   assign req_cx = clamp_pos(CMP_BITS'(req_col), w_lim);
   assign req_cy = clamp_pos(CMP_BITS'(req_row), h_lim);
   assign scan_r = clamp_ofs(cy_ff, du_ff, h_lim);
   assign scan_k = clamp_ofs(cx_ff, dv_ff, w_lim);
   assign load_in_range = (CMP_BITS'(req_col) < CMP_BITS'(MAX_SIDE))
                       && (CMP_BITS'(req_row) < CMP_BITS'(MAX_SIDE))
                       && (req_layer != LAYER_NONE);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept = req_valid && !req_stall;

   assign scan_done = (layer_ff == LAYER_CENTRE) && (du_ff == ofs_type'(WINDOW - 1))
                   && (dv_ff == ofs_type'(WINDOW - 1));

   always_comb begin
      mem_en = 1'b0;
      mem_we = 1'b0;
      mem_addr = '0;
      if (accept && req_op == OP_LOAD) begin
         mem_en = load_in_range;
         mem_we = 1'b1;
         mem_addr = {req_layer, coord_type'(req_row), coord_type'(req_col)};
      end else if (accept) begin
         mem_en = 1'b1;
         mem_addr = {LAYER_CENTRE, req_cy, req_cx};
      end else if (state_ff == ST_SCAN) begin
         mem_en = 1'b1;
         mem_addr = {layer_ff, scan_r, scan_k};
      end
   end

   sset_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_layers (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_pixel_value),
      .rdata (mem_rdata)
   );

   assign rd_pix = signed'(mem_rdata);

   always_comb begin
      mag = centre_ff[PIX_BITS-1] ? -(PIX_BITS+1)'(centre_ff) : (PIX_BITS+1)'(centre_ff);
      hit = ((centre_ff < mn_ff) || (centre_ff > mx_ff))
         && (mag > (PIX_BITS+1)'(threshold_ff));
   end

   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      du_in = du_ff;
      dv_in = dv_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      rd_valid_in = 1'b0;
      rd_centre_in = 1'b0;
      centre_in = centre_ff;
      mn_in = mn_ff;
      mx_in = mx_ff;

      if (rd_valid_ff) begin
         if (rd_centre_ff) begin
            centre_in = rd_pix;
         end else begin
            if (rd_pix < mn_ff) begin
               mn_in = rd_pix;
            end
            if (rd_pix > mx_ff) begin
               mx_in = rd_pix;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_TEST) begin
               state_in = ST_SCAN;
               cx_in = req_cx;
               cy_in = req_cy;
               layer_in = LAYER_LOWER;
               du_in = '0;
               dv_in = '0;
               mn_in = PIX_MAX;
               mx_in = PIX_MIN;
               rd_valid_in = 1'b1;
               rd_centre_in = 1'b1;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            if (scan_done) begin
               state_in = ST_LAST;
            end else if (dv_ff == ofs_type'(WINDOW - 1)) begin
               dv_in = '0;
               if (du_ff == ofs_type'(WINDOW - 1)) begin
                  du_in = '0;
                  layer_in = (layer_ff == LAYER_LOWER) ? LAYER_UPPER : LAYER_CENTRE;
               end else begin
                  du_in = du_ff + ofs_type'(1);
               end
            end else if ((layer_ff == LAYER_CENTRE) && (du_ff == ofs_type'(HALF))
                         && (dv_ff == ofs_type'(HALF - 1))) begin
               // The middle of the centre layer is the tested pixel itself.
               dv_in = dv_ff + ofs_type'(2);
            end else begin
               dv_in = dv_ff + ofs_type'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in = rsp_hit_ff;
      rsp_centre_in = rsp_centre_ff;
      rsp_min_in = rsp_min_ff;
      rsp_max_in = rsp_max_ff;
      if (accept && req_op == OP_LOAD) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = 1'b0;
         rsp_centre_in = '0;
         rsp_min_in = '0;
         rsp_max_in = '0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = hit;
         rsp_centre_in = centre_ff;
         rsp_min_in = mn_ff;
         rsp_max_in = mx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         rd_centre_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_valid_ff <= rd_valid_in;
         rd_centre_ff <= rd_centre_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff <= layer_in;
      du_ff <= du_in;
      dv_ff <= dv_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      centre_ff <= centre_in;
      mn_ff <= mn_in;
      mx_ff <= mx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_centre_ff <= rsp_centre_in;
      rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_keypoint = rsp_hit_ff;
   assign rsp_centre_value = rsp_centre_ff;
   assign rsp_neigh_min = rsp_min_ff;
   assign rsp_neigh_max = rsp_max_ff;

endmodule

// ===== rtl/sset_ram.sv =====
module sset_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/tb_scale_space_extremum_test_top.sv =====
module tb_scale_space_extremum_test_top
   import sset_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                       is_keypoint;
      logic signed [PIX_BITS-1:0] centre_value;
      logic signed [PIX_BITS-1:0] neigh_min;
      logic signed [PIX_BITS-1:0] neigh_max;
   } verdict_type;

   typedef struct packed {
      logic                       op;
      logic [LAYER_BITS-1:0]      layer;
      logic [COL_BITS-1:0]        col;
      logic [ROW_BITS-1:0]        row;
      logic signed [PIX_BITS-1:0] pixel;
      logic                       typed;
      verdict_type                typed_want;
   } script_row_type;

   localparam verdict_type NO_HIT = '0;
   localparam int SCRIPT_LEN = 20;
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int PIX_MAX = 32767;
   localparam int PIX_MIN = -32768;

   // Loads answer with an all-zero result, so their expectations are written out here.
   script_row_type directed_script [SCRIPT_LEN] = '{
      '{OP_LOAD, LAYER_LOWER,  6'd0,  6'd0,  16'sh8000, 1'b1, NO_HIT},
      '{OP_LOAD, LAYER_UPPER,  6'd63, 6'd63, 16'sh7FFF, 1'b1, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd63, 6'd0,  16'sh0100, 1'b1, NO_HIT},
      '{OP_LOAD, LAYER_NONE,   6'd10, 6'd10, 16'shFFFF, 1'b1, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd0,  6'd63, 16'sh5555, 1'b1, NO_HIT},
      '{OP_LOAD, LAYER_LOWER,  6'd63, 6'd63, 16'shAAAA, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_LOWER,  6'd0,  6'd0,  16'sh0000, 1'b0, NO_HIT},
      '{OP_TEST, LAYER_NONE,   6'd63, 6'd63, 16'shFFFF, 1'b0, NO_HIT},
      '{OP_TEST, LAYER_UPPER,  6'd63, 6'd0,  16'sh0000, 1'b0, NO_HIT},
      '{OP_TEST, LAYER_CENTRE, 6'd0,  6'd63, 16'shAAAA, 1'b0, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd1,  6'd1,  16'sh7FFF, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_LOWER,  6'd1,  6'd1,  16'sh0000, 1'b0, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd1,  6'd1,  16'sh8000, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_LOWER,  6'd1,  6'd1,  16'sh0000, 1'b0, NO_HIT},
      '{OP_LOAD, LAYER_LOWER,  6'd0,  6'd0,  16'sh0000, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_LOWER,  6'd1,  6'd1,  16'sh0000, 1'b0, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd1,  6'd1,  16'sh0000, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_LOWER,  6'd1,  6'd1,  16'sh0000, 1'b0, NO_HIT},
      '{OP_LOAD, LAYER_CENTRE, 6'd10, 6'd10, 16'sh012C, 1'b1, NO_HIT},
      '{OP_TEST, LAYER_UPPER,  6'd10, 6'd10, 16'sh0000, 1'b0, NO_HIT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = OP_LOAD;
   logic [1:0]                 req_layer = LAYER_LOWER;
   logic [5:0]                 req_col = '0;
   logic [5:0]                 req_row = '0;
   logic signed [15:0]         req_pixel_value = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_is_keypoint;
   logic signed [15:0]         rsp_centre_value;
   logic signed [15:0]         rsp_neigh_min;
   logic signed [15:0]         rsp_neigh_max;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = REG_THRESHOLD;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   logic signed [PIX_BITS-1:0] pyramid_px [3][CELLS];
   bit                         pyramid_loaded [3][CELLS];
   logic [LAYER_BITS-1:0]      data_layers [3] = '{LAYER_LOWER, LAYER_CENTRE, LAYER_UPPER};
   int                         threshold_reg = 0;
   int                         width_reg = MAX_SIDE;
   int                         height_reg = MAX_SIDE;

   verdict_type                pending_verdicts [$];
   int                         mismatch_count = 0;
   int                         accepted_items = 0;
   bit                         calm = 1'b0;
   int                         hold_left = 0;
   bit                         hold_level = 1'b0;

   scale_space_extremum_test_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_layer        (req_layer),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_keypoint  (rsp_is_keypoint),
      .rsp_centre_value (rsp_centre_value),
      .rsp_neigh_min    (rsp_neigh_min),
      .rsp_neigh_max    (rsp_neigh_max),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_side(input int v);
      if (v < 1) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   function automatic int clamp_to(input int v, input int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   function automatic int px_at(input logic [LAYER_BITS-1:0] layer, input int r, input int k);
      return int'(pyramid_px[layer][r * MAX_SIDE + k]);
   endfunction

   function automatic verdict_type judge_position(input int col, input int row);
      verdict_type v;
      int w, h, cx, cy, r, k, centre, mn, mx, a, b, c, mag;
      w = eff_side(width_reg);
      h = eff_side(height_reg);
      cx = clamp_to(col, w);
      cy = clamp_to(row, h);
      centre = px_at(LAYER_CENTRE, cy, cx);
      mn = 1 << 20;
      mx = -(1 << 20);
      for (int du = -HALF; du <= HALF; du++) begin
         for (int dv = -HALF; dv <= HALF; dv++) begin
            r = clamp_to(cy + du, h);
            k = clamp_to(cx + dv, w);
            a = px_at(LAYER_LOWER, r, k);
            b = px_at(LAYER_UPPER, r, k);
            mn = (a < mn) ? a : mn;
            mx = (a > mx) ? a : mx;
            mn = (b < mn) ? b : mn;
            mx = (b > mx) ? b : mx;
            if (du != 0 || dv != 0) begin
               c = px_at(LAYER_CENTRE, r, k);
               mn = (c < mn) ? c : mn;
               mx = (c > mx) ? c : mx;
            end
         end
      end
      mag = (centre < 0) ? -centre : centre;
      v.is_keypoint = (centre < mn || centre > mx) && mag > threshold_reg;
      v.centre_value = PIX_BITS'(centre);
      v.neigh_min = PIX_BITS'(mn);
      v.neigh_max = PIX_BITS'(mx);
      return v;
   endfunction

   function automatic logic signed [PIX_BITS-1:0] small_pixel();
      return PIX_BITS'(int'($urandom_range(0, 1023)) - 512);
   endfunction

   function automatic int pick_coord(input int lim);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, MAX_SIDE - 1);
         1: return 0;
         2: return lim - 1;
         3: return (lim < MAX_SIDE) ? $urandom_range(lim, MAX_SIDE - 1) : MAX_SIDE - 1;
         4: return lim - 1 - int'($urandom_range(0, ((lim < 4) ? lim : 4) - 1));
         default: return $urandom_range(0, ((lim < 6) ? lim : 6) - 1);
      endcase
   endfunction

   task automatic issue(input logic op, input logic [LAYER_BITS-1:0] layer, input int col,
                        input int row, input logic signed [PIX_BITS-1:0] pix,
                        input bit typed = 1'b0, input verdict_type typed_want = '0);
      verdict_type want;
      if (!calm && $urandom_range(0, 5) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_layer <= layer;
      req_col <= COL_BITS'(col);
      req_row <= ROW_BITS'(row);
      req_pixel_value <= pix;
      do @(posedge clock); while (req_stall);
      want = '0;
      if (op == OP_LOAD) begin
         if (layer != LAYER_NONE) begin
            pyramid_px[layer][row * MAX_SIDE + col] = pix;
            pyramid_loaded[layer][row * MAX_SIDE + col] = 1'b1;
            accepted_items++;
         end
      end else begin
         want = judge_position(col, row);
         accepted_items++;
      end
      if (typed) want = typed_want;
      pending_verdicts.insert(pending_verdicts.size(), want);
   endtask

   // Every pixel a test can read must have been loaded first.
   task automatic cover_window(input int col, input int row);
      int w, h, cx, cy, r, k;
      w = eff_side(width_reg);
      h = eff_side(height_reg);
      cx = clamp_to(col, w);
      cy = clamp_to(row, h);
      for (int du = -HALF; du <= HALF; du++) begin
         for (int dv = -HALF; dv <= HALF; dv++) begin
            r = clamp_to(cy + du, h);
            k = clamp_to(cx + dv, w);
            foreach (data_layers[i]) begin
               if (!pyramid_loaded[data_layers[i]][r * MAX_SIDE + k])
                  issue(OP_LOAD, data_layers[i], k, r, small_pixel());
            end
         end
      end
   endtask

   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      logic [CSR_DATA_BITS-1:0] mask, word;
      mask = (idx == REG_THRESHOLD) ? 16'h7FFF : 16'h007F;
      word = (CSR_DATA_BITS'($urandom) & ~mask) | (CSR_DATA_BITS'(value) & mask);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= word;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_THRESHOLD: threshold_reg = int'(word & mask);
         REG_WIDTH:     width_reg = int'(word & mask);
         REG_HEIGHT:    height_reg = int'(word & mask);
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic random_round(input int n);
      int start, kind, col, row, w, h, cx, cy, lo, hi, val, nmin, nmax;
      bit paused;
      verdict_type j;
      start = accepted_items;
      paused = 1'b0;
      while (accepted_items - start < n) begin
         if (!paused && accepted_items - start >= n / 2) begin
            drain_results();
            paused = 1'b1;
         end
         w = eff_side(width_reg);
         h = eff_side(height_reg);
         col = pick_coord(w);
         row = pick_coord(h);
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            cover_window(col, row);
            cx = clamp_to(col, w);
            cy = clamp_to(row, h);
            repeat ($urandom_range(0, 3))
               issue(OP_LOAD, data_layers[$urandom_range(0, 2)],
                     clamp_to(cx + int'($urandom_range(0, 2)) - 1, w),
                     clamp_to(cy + int'($urandom_range(0, 2)) - 1, h), small_pixel());
            // Push the centre just past the neighbour range, sometimes right onto a tie.
            if ($urandom_range(0, 9) < 7) begin
               j = judge_position(col, row);
               nmin = j.neigh_min;
               nmax = j.neigh_max;
               lo = (nmax + 1 > threshold_reg + int'($urandom_range(0, 1))) ?
                    nmax + 1 : threshold_reg + int'($urandom_range(0, 1));
               hi = (nmin - 1 < -threshold_reg - int'($urandom_range(0, 1))) ?
                    nmin - 1 : -threshold_reg - int'($urandom_range(0, 1));
               if (lo <= PIX_MAX && (hi < PIX_MIN || $urandom_range(0, 1) == 1)) begin
                  val = lo + int'($urandom_range(0, 200));
                  val = (val > PIX_MAX) ? PIX_MAX : val;
               end else if (hi >= PIX_MIN) begin
                  val = hi - int'($urandom_range(0, 200));
                  val = (val < PIX_MIN) ? PIX_MIN : val;
               end else begin
                  val = nmax;
               end
               if ($urandom_range(0, 9) == 0) val = ($urandom_range(0, 1) == 1) ? nmax : nmin;
               issue(OP_LOAD, LAYER_CENTRE, cx, cy, PIX_BITS'(val));
            end
            issue(OP_TEST, LAYER_BITS'($urandom_range(0, 3)), col, row, PIX_BITS'($urandom));
         end else if (kind < 75) begin
            cover_window(col, row);
            issue(OP_TEST, LAYER_BITS'($urandom_range(0, 3)), col, row, PIX_BITS'($urandom));
         end else if (kind < 92) begin
            issue(OP_LOAD, data_layers[$urandom_range(0, 2)], col, row, PIX_BITS'($urandom));
         end else begin
            issue(OP_LOAD, LAYER_NONE, $urandom_range(0, MAX_SIDE - 1),
                  $urandom_range(0, MAX_SIDE - 1), PIX_BITS'($urandom));
         end
      end
   endtask

   task automatic run_phase(input int thr, input int w, input int h, input int n,
                            input bit last);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      calm = last;
      random_round(n);
   endtask

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_left == 0) begin
            hold_level = ($urandom_range(0, 2) == 0);
            hold_left = hold_level ? $urandom_range(1, 7) : $urandom_range(1, 30);
         end
         rsp_stall <= hold_level;
         hold_left--;
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("result transaction with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_is_keypoint !== want.is_keypoint) begin
               $error("is_keypoint: expected %0d, got %0d", want.is_keypoint, rsp_is_keypoint);
               mismatch_count++;
            end
            if (rsp_centre_value !== want.centre_value) begin
               $error("centre_value: expected %0d, got %0d", want.centre_value,
                      rsp_centre_value);
               mismatch_count++;
            end
            if (rsp_neigh_min !== want.neigh_min) begin
               $error("neigh_min: expected %0d, got %0d", want.neigh_min, rsp_neigh_min);
               mismatch_count++;
            end
            if (rsp_neigh_max !== want.neigh_max) begin
               $error("neigh_max: expected %0d, got %0d", want.neigh_max, rsp_neigh_max);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      foreach (directed_script[i]) begin
         if (directed_script[i].op == OP_TEST)
            cover_window(directed_script[i].col, directed_script[i].row);
         issue(directed_script[i].op, directed_script[i].layer, directed_script[i].col,
               directed_script[i].row, directed_script[i].pixel, directed_script[i].typed,
               directed_script[i].typed_want);
      end
      random_round(200);
      run_phase(32767, 127, 0, 150, 1'b0);
      run_phase(0, 1, 1, 100, 1'b0);
      run_phase($urandom_range(0, 300), 4, 4, 250, 1'b0);
      run_phase($urandom_range(0, 300), 5, 3, 250, 1'b0);
      run_phase($urandom_range(0, 2000), 64, 64, 200, 1'b0);
      run_phase($urandom_range(0, 300), 0, 127, 150, 1'b0);
      run_phase($urandom_range(0, 32767), $urandom_range(1, 64), $urandom_range(1, 64), 250,
                1'b0);
      run_phase(100, 8, 8, 200, 1'b1);
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
